// ===== sv/ngs_pkg.sv =====
// ----------------------------------------------------------------------------
// ngs_pkg
// Shared types and constants of the noise gate gain sequencer.
// ----------------------------------------------------------------------------
package ngs_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned EnvW    = 23;
  localparam int unsigned GainW   = 24;
  localparam int unsigned HoldW   = 25;
  localparam int unsigned HoldLenW = 24;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [GainW-1:0] UnityGain = 24'd8388608;
  localparam logic [HoldW-1:0] HoldMax   = 25'd33554431;

  typedef enum logic [ModeW-1:0] {
    MODE_INIT    = 3'd0,
    MODE_CLOSED  = 3'd1,
    MODE_ATTACK  = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_RELEASE = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OPEN_THR  = 3'd0,
    REG_CLOSE_THR = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_HOLD_LEN  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [EnvW-1:0]     open_thr;
    logic [EnvW-1:0]     close_thr;
    logic [GainW-1:0]    attack_step;
    logic [GainW-1:0]    release_step;
    logic [HoldLenW-1:0] hold_len;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [GainW-1:0] gain;
  } step_t;

endpackage

// ===== sv/ngs_fsm.sv =====
// ----------------------------------------------------------------------------
// ngs_fsm
// Gate mode sequencer: holds mode, gain level and hold counter and advances
// them by one step for each sample.
// ----------------------------------------------------------------------------
module ngs_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [ngs_pkg::EnvW-1:0]    envelope_i,
  input  ngs_pkg::cfg_t               cfg_i,
  output ngs_pkg::step_t              next_o
);

  ngs_pkg::mode_e              mode_q, mode_d;
  logic [ngs_pkg::GainW-1:0]   gain_q, gain_d;
  logic [ngs_pkg::HoldW-1:0]   hold_q, hold_d;

  logic                        above_open;
  logic                        above_close;
  logic [ngs_pkg::GainW:0]     attack_sum;
  logic                        attack_over;
  logic                        release_under;
  logic [ngs_pkg::HoldW-1:0]   hold_inc;
  logic                        hold_done;

  assign above_open    = envelope_i > cfg_i.open_thr;
  assign above_close   = envelope_i > cfg_i.close_thr;
  assign attack_sum    = {1'b0, gain_q} + {1'b0, cfg_i.attack_step};
  assign attack_over   = attack_sum > {1'b0, ngs_pkg::UnityGain};
  assign release_under = cfg_i.release_step > gain_q;
  assign hold_inc      = (hold_q < ngs_pkg::HoldMax) ? hold_q + 1'b1 : hold_q;
  assign hold_done     = hold_inc > {1'b0, cfg_i.hold_len};

  always_comb begin
    mode_d = mode_q;
    case (mode_q)
      ngs_pkg::MODE_INIT: begin
        mode_d = ngs_pkg::MODE_CLOSED;
      end
      ngs_pkg::MODE_CLOSED: begin
        if (above_open) mode_d = ngs_pkg::MODE_ATTACK;
      end
      ngs_pkg::MODE_ATTACK: begin
        if (!above_open) begin
          mode_d = ngs_pkg::MODE_RELEASE;
        end else if (attack_over) begin
          mode_d = ngs_pkg::MODE_OPEN;
        end
      end
      ngs_pkg::MODE_OPEN: begin
        if (!above_close && hold_done) mode_d = ngs_pkg::MODE_RELEASE;
      end
      ngs_pkg::MODE_RELEASE: begin
        if (above_close) begin
          mode_d = ngs_pkg::MODE_ATTACK;
        end else if (release_under) begin
          mode_d = ngs_pkg::MODE_CLOSED;
        end
      end
      default: begin
        mode_d = ngs_pkg::MODE_INIT;
      end
    endcase
  end

  always_comb begin
    gain_d = gain_q;
    hold_d = hold_q;
    case (mode_q)
      ngs_pkg::MODE_INIT: begin
        gain_d = '0;
      end
      ngs_pkg::MODE_ATTACK: begin
        if (above_open) begin
          if (attack_over) begin
            gain_d = ngs_pkg::UnityGain;
            hold_d = '0;
          end else begin
            gain_d = attack_sum[ngs_pkg::GainW-1:0];
          end
        end
      end
      ngs_pkg::MODE_OPEN: begin
        hold_d = above_close ? '0 : hold_inc;
      end
      ngs_pkg::MODE_RELEASE: begin
        if (!above_close) begin
          gain_d = release_under ? '0 : gain_q - cfg_i.release_step;
        end
      end
      default: begin
        gain_d = gain_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ngs_pkg::MODE_INIT;
      gain_q <= '0;
      hold_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      gain_q <= gain_d;
      hold_q <= hold_d;
    end
  end

  assign next_o.mode = mode_d;
  assign next_o.gain = gain_d;

  a_gain_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= ngs_pkg::UnityGain)
    else $error("gain level above unity");

  a_open_unity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ngs_pkg::MODE_OPEN |-> gain_q == ngs_pkg::UnityGain)
    else $error("open mode without unity gain");

  a_closed_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ngs_pkg::MODE_CLOSED |-> gain_q == '0)
    else $error("closed mode with nonzero gain");

endmodule

// ===== sv/ngs_scale.sv =====
// ----------------------------------------------------------------------------
// ngs_scale
// Sample scaler: signed sample times Q1.23 gain, floor shift by 23, saturate.
// ----------------------------------------------------------------------------
module ngs_scale (
  input  logic signed [ngs_pkg::SampleW-1:0] sample_i,
  input  logic        [ngs_pkg::GainW-1:0]   gain_i,
  output logic signed [ngs_pkg::SampleW-1:0] scaled_o
);

  localparam int unsigned ProdW = ngs_pkg::SampleW + ngs_pkg::GainW + 1;
  localparam int unsigned ShrW  = ProdW - 23;

  logic signed [ProdW-1:0] prod;
  logic signed [ShrW-1:0]  shr;

  assign prod = $signed(sample_i) * $signed({1'b0, gain_i});
  assign shr  = prod[ProdW-1:23];

  always_comb begin
    if (shr > $signed(ShrW'(24'sh7FFFFF))) begin
      scaled_o = 24'sh7FFFFF;
    end else if (shr < -$signed(ShrW'(25'sh0800000))) begin
      scaled_o = 24'sh800000;
    end else begin
      scaled_o = shr[ngs_pkg::SampleW-1:0];
    end
  end

endmodule

// ===== sv/noise_gate_gain_sequencer.sv =====
// ----------------------------------------------------------------------------
// noise_gate_gain_sequencer
// Noise gate with attack, hold and release gain ramps over a sample stream.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tdata: audio_sample, envelope
//  m_axis   | out       | m_axis_tvalid/tready    | tdata: gain_out, gated_sample, gate_mode
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One sample per cycle while the output is not stalled; the result passes
//  through the input register, gate step register and scaled output register.
//  The gate step adds, subtracts and compares; the scaler is one 24x25 multiply.
//  Reset puts the gate in init mode with zero gain and default registers.
//  A stalled output holds the whole pipeline and drops s_axis_tready.
// ----------------------------------------------------------------------------
module noise_gate_gain_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // audio_sample, envelope, pad
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [55:0]                    m_axis_tdata,  // gain_out, gated_sample, gate_mode, pad
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ngs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ngs_pkg::CfgDataW-1:0]   cfg_data_i
);

  ngs_pkg::cfg_t                       cfg_q;
  logic                                adv;

  logic                                in_vld_q;
  logic [ngs_pkg::SampleW-1:0]         in_sample_q;
  logic [ngs_pkg::EnvW-1:0]            in_env_q;

  ngs_pkg::step_t                      next_step;
  logic                                step_vld_q;
  ngs_pkg::step_t                      step_q;
  logic [ngs_pkg::SampleW-1:0]         step_sample_q;

  logic signed [ngs_pkg::SampleW-1:0]  scaled;
  logic                                out_vld_q;
  logic [ngs_pkg::GainW-1:0]           out_gain_q;
  logic [ngs_pkg::SampleW-1:0]         out_sample_q;
  ngs_pkg::mode_e                      out_mode_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_thr     <= '0;
      cfg_q.close_thr    <= '0;
      cfg_q.attack_step  <= ngs_pkg::UnityGain;
      cfg_q.release_step <= ngs_pkg::UnityGain;
      cfg_q.hold_len     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ngs_pkg::REG_OPEN_THR:  cfg_q.open_thr     <= cfg_data_i[ngs_pkg::EnvW-1:0];
        ngs_pkg::REG_CLOSE_THR: cfg_q.close_thr    <= cfg_data_i[ngs_pkg::EnvW-1:0];
        ngs_pkg::REG_ATTACK:    cfg_q.attack_step  <= cfg_data_i;
        ngs_pkg::REG_RELEASE:   cfg_q.release_step <= cfg_data_i;
        ngs_pkg::REG_HOLD_LEN:  cfg_q.hold_len     <= cfg_data_i;
        default:                cfg_q              <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      step_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (adv) begin
      in_vld_q   <= s_axis_tvalid;
      step_vld_q <= in_vld_q;
      out_vld_q  <= step_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_sample_q   <= s_axis_tdata[23:0];
      in_env_q      <= s_axis_tdata[46:24];
      step_q        <= next_step;
      step_sample_q <= in_sample_q;
      out_gain_q    <= step_q.gain;
      out_sample_q  <= scaled;
      out_mode_q    <= step_q.mode;
    end
  end

  ngs_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv && in_vld_q),
    .envelope_i (in_env_q),
    .cfg_i      (cfg_q),
    .next_o     (next_step)
  );

  ngs_scale u_scale (
    .sample_i (step_sample_q),
    .gain_i   (step_q.gain),
    .scaled_o (scaled)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_mode_q, out_sample_q, out_gain_q};

  a_step_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step_vld_q |=> out_vld_q)
    else $error("gate step lost before output register");

  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(step_vld_q) && $stable(in_vld_q))
    else $error("pipeline moved during output stall");

  a_out_open_unity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_mode_q == ngs_pkg::MODE_OPEN |-> out_gain_q == ngs_pkg::UnityGain)
    else $error("open result without unity gain");

endmodule

// ===== dv/noise_gate_gain_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_gate_gain_sequencer_tb
// Self-checking bench for the noise gate gain sequencer. A behavioral model of
// the gate tracks mode, gain and hold count for every accepted sample; each
// output transfer is compared field by field with the oldest prediction.
// Directed sequences walk the ramp corner cases, then randomized phases with
// changing register settings drive envelope segments through every mode
// under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module noise_gate_gain_sequencer_tb;

  localparam int unsigned SampleW  = ngs_pkg::SampleW;
  localparam int unsigned EnvW     = ngs_pkg::EnvW;
  localparam int unsigned GainW    = ngs_pkg::GainW;
  localparam int unsigned HoldW    = ngs_pkg::HoldW;
  localparam int unsigned HoldLenW = ngs_pkg::HoldLenW;
  localparam int unsigned CfgIdxW  = ngs_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = ngs_pkg::CfgDataW;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RegCount  = 5;
  localparam int unsigned PrintCap  = 100;
  localparam logic [EnvW-1:0]     EnvMax    = '1;
  localparam logic [GainW-1:0]    StepMax   = '1;
  localparam logic [HoldLenW-1:0] HoldLenMax = '1;

  typedef struct {
    logic [GainW-1:0]   gain;
    logic [SampleW-1:0] gated;
    ngs_pkg::mode_e     mode;
  } gate_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata;   // audio_sample, envelope, pad
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [55:0]         m_axis_tdata;   // gain_out, gated_sample, gate_mode, pad
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // model of the gate
  ngs_pkg::cfg_t    gate_cfg;
  ngs_pkg::mode_e   cur_mode;
  logic [GainW-1:0] cur_gain;
  logic [HoldW-1:0] hold_cnt;

  gate_result_t gate_results_q[$];
  int unsigned  err_count     = 0;
  int unsigned  idle_cycles   = 0;
  int unsigned  tx_burst_left = 0;
  bit           tx_no_gap     = 1'b0;
  int unsigned  rx_mode       = 1;
  int unsigned  rx_stall_left = 0;

  noise_gate_gain_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    err_count++;
    if (err_count <= PrintCap) begin
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want_v);
    end
  endtask

  // advance the gate model by one sample
  task automatic gate_step(input logic [SampleW-1:0] smp, input logic [EnvW-1:0] env,
                           output gate_result_t r);
    logic [GainW+1:0] sum;
    longint           prod;
    longint           q;
    case (cur_mode)
      ngs_pkg::MODE_INIT: begin
        cur_gain = '0;
        cur_mode = ngs_pkg::MODE_CLOSED;
      end
      ngs_pkg::MODE_CLOSED: begin
        if (env > gate_cfg.open_thr) cur_mode = ngs_pkg::MODE_ATTACK;
      end
      ngs_pkg::MODE_ATTACK: begin
        if (env > gate_cfg.open_thr) begin
          sum = {2'b00, cur_gain} + {2'b00, gate_cfg.attack_step};
          if (sum > {2'b00, ngs_pkg::UnityGain}) begin
            cur_gain = ngs_pkg::UnityGain;
            hold_cnt = '0;
            cur_mode = ngs_pkg::MODE_OPEN;
          end else begin
            cur_gain = sum[GainW-1:0];
          end
        end else begin
          cur_mode = ngs_pkg::MODE_RELEASE;
        end
      end
      ngs_pkg::MODE_OPEN: begin
        if (env > gate_cfg.close_thr) begin
          hold_cnt = '0;
        end else begin
          if (hold_cnt < ngs_pkg::HoldMax) hold_cnt = hold_cnt + 1'b1;
          if (hold_cnt > {1'b0, gate_cfg.hold_len}) cur_mode = ngs_pkg::MODE_RELEASE;
        end
      end
      ngs_pkg::MODE_RELEASE: begin
        if (env > gate_cfg.close_thr) begin
          cur_mode = ngs_pkg::MODE_ATTACK;
        end else if (gate_cfg.release_step > cur_gain) begin
          cur_gain = '0;
          cur_mode = ngs_pkg::MODE_CLOSED;
        end else begin
          cur_gain = cur_gain - gate_cfg.release_step;
        end
      end
      default: cur_mode = ngs_pkg::MODE_INIT;
    endcase
    if (cur_gain > ngs_pkg::UnityGain) cur_gain = ngs_pkg::UnityGain;

    prod = longint'($signed(smp)) * longint'({1'b0, cur_gain});
    q = prod >>> 23;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    r.gain  = cur_gain;
    r.gated = q[SampleW-1:0];
    r.mode  = cur_mode;
  endtask

  task automatic send_sample(input logic [SampleW-1:0] smp, input logic [EnvW-1:0] env);
    int unsigned  gap;
    gate_result_t r;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 16);
      if (tx_no_gap) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 20);
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    tx_burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, env, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gate_step(smp, env, r);
    gate_results_q.push_back(r);
  endtask

  // hold input until every predicted result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    tx_burst_left = 0;
    while (gate_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ngs_pkg::REG_OPEN_THR:  gate_cfg.open_thr     = data[EnvW-1:0];
      ngs_pkg::REG_CLOSE_THR: gate_cfg.close_thr    = data[EnvW-1:0];
      ngs_pkg::REG_ATTACK:    gate_cfg.attack_step  = data;
      ngs_pkg::REG_RELEASE:   gate_cfg.release_step = data;
      ngs_pkg::REG_HOLD_LEN:  gate_cfg.hold_len     = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] open_thr,
                                input logic [CfgDataW-1:0] close_thr,
                                input logic [GainW-1:0] atk, input logic [GainW-1:0] rel,
                                input logic [HoldLenW-1:0] hold);
    wait_drained();
    write_reg(ngs_pkg::REG_OPEN_THR, open_thr);
    write_reg(ngs_pkg::REG_CLOSE_THR, close_thr);
    write_reg(ngs_pkg::REG_ATTACK, atk);
    write_reg(ngs_pkg::REG_RELEASE, rel);
    write_reg(ngs_pkg::REG_HOLD_LEN, hold);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CfgIdxW'($urandom_range(RegCount, 2**CfgIdxW - 1)), CfgDataW'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // default registers: thresholds zero, unity steps, no hold
  task automatic test_reset_sequence();
    send_sample(24'h123456, 23'd0);       // init step -> closed
    send_sample(24'h654321, 23'd0);       // equal to threshold, stays closed
    send_sample(24'h000001, 23'd1);       // closed -> attack
    send_sample(24'h7FFFFF, EnvMax);      // exactly unity, stays in attack
    send_sample(24'h800000, EnvMax);      // passes unity -> open
    send_sample(24'hFFFFFF, 23'd0);       // hold passed -> release
    send_sample(24'h7FFFFF, 23'd0);       // exactly zero, stays in release
    send_sample(24'h800000, 23'd0);       // -> closed
    send_sample(24'h000000, 23'd5);       // -> attack
    send_sample(24'h400000, 23'd0);       // attack drop -> release
    send_sample(24'hC00000, 23'd3);       // release rise -> attack
    send_sample(24'h000010, 23'd0);       // -> release
  endtask

  task automatic test_ramp_extremes();
    apply_settings(24'd100, 24'd50, '0, '0, 24'd2);
    send_sample(24'h7FFFFF, 23'd0);       // zero step, stays in release
    send_sample(24'h7FFFFF, 23'd101);     // -> attack
    send_sample(24'h800000, 23'd200);     // zero step, gain holds
    send_sample(24'h000100, 23'd100);     // -> release
    send_sample(24'hFFFF00, 23'd50);      // zero step in release
    send_sample(24'h3FFFFF, 23'd51);      // -> attack
    apply_settings(24'd100, 24'd50, StepMax, StepMax, 24'd2);
    send_sample(24'h7FFFFF, 23'd101);     // oversized step -> open
    send_sample(24'h800000, 23'd0);
    send_sample(24'h000001, 23'd0);
    send_sample(24'hFFFFFF, 23'd51);      // restart hold
    send_sample(24'h555555, 23'd0);
    send_sample(24'hAAAAAA, 23'd0);
    send_sample(24'h0F0F0F, 23'd0);       // hold passed -> release
    send_sample(24'hF0F0F0, 23'd0);       // oversized release -> closed
  endtask

  task automatic test_random_settings();
    logic [CfgDataW-1:0] o_thr, c_thr;
    logic [GainW-1:0]    atk, rel;
    logic [HoldLenW-1:0] hold;
    logic [EnvW-1:0]     loud_env, quiet_env, mid_env, env;
    logic [SampleW-1:0]  smp;
    int unsigned         seg_left, seg_kind, pause_at, n_items;
    for (int p = 0; p < 10; p++) begin
      o_thr = {1'($urandom_range(0, 1)), EnvW'($urandom)};
      c_thr = {1'($urandom_range(0, 1)), EnvW'($urandom_range(0, o_thr[EnvW-1:0]))};
      atk   = GainW'($urandom_range(ngs_pkg::UnityGain / 40, ngs_pkg::UnityGain / 2));
      rel   = GainW'($urandom_range(ngs_pkg::UnityGain / 40, ngs_pkg::UnityGain / 2));
      hold  = HoldLenW'($urandom_range(0, 24));
      case (p)
        1: begin o_thr = '0; c_thr = '0; end
        2: begin o_thr = '1; c_thr = '1; end
        3: begin atk = 24'd1; rel = ngs_pkg::UnityGain; end
        4: begin atk = ngs_pkg::UnityGain; rel = 24'd1; end
        5: begin atk = StepMax; rel = StepMax; hold = '0; end
        6: begin atk = '0; c_thr = {1'b0, EnvMax}; end
        7: hold = HoldLenMax;
        8: begin hold = '0; rel = '0; end
        default: ;
      endcase
      apply_settings(o_thr, c_thr, atk, rel, hold);
      rx_mode   = p % 3;
      tx_no_gap = (p % 4 == 0);
      n_items   = 105;
      pause_at  = $urandom_range(10, n_items - 10);
      seg_left  = 0;
      seg_kind  = 0;
      for (int i = 0; i < n_items; i++) begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 99);
          seg_left = $urandom_range(1, 24);
        end
        seg_left--;
        if (gate_cfg.open_thr == EnvMax) loud_env = EnvMax;
        else loud_env = EnvW'($urandom_range(gate_cfg.open_thr + 1, EnvMax));
        quiet_env = EnvW'($urandom_range(0, gate_cfg.close_thr));
        mid_env   = EnvW'($urandom_range(gate_cfg.close_thr, gate_cfg.open_thr));
        if (seg_kind < 30) env = loud_env;
        else if (seg_kind < 60) env = quiet_env;
        else if (seg_kind < 70) env = mid_env;
        else if (seg_kind < 85) env = EnvW'($urandom);
        else env = i[0] ? loud_env : quiet_env;
        case ($urandom_range(0, 19))
          0: smp = 24'h800000;
          1: smp = 24'h7FFFFF;
          2: smp = 24'hFFFFFF;
          default: smp = SampleW'($urandom);
        endcase
        if (i == pause_at) wait_drained();
        send_sample(smp, env);
      end
    end
  endtask

  // compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    gate_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (gate_results_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = gate_results_q.pop_front();
        if (m_axis_tdata[23:0] !== want.gain)
          report_mismatch("gain_out", m_axis_tdata[23:0], want.gain);
        if (m_axis_tdata[47:24] !== want.gated)
          report_mismatch("gated_sample", m_axis_tdata[47:24], want.gated);
        if (m_axis_tdata[50:48] !== want.mode)
          report_mismatch("gate_mode", m_axis_tdata[50:48], want.mode);
      end
    end
  end

  // output stall pattern
  always @(posedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: begin
          if ($urandom_range(0, 3) == 0) begin
            rx_stall_left = $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        default: m_axis_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    gate_cfg      = '{open_thr: '0, close_thr: '0, attack_step: ngs_pkg::UnityGain,
                      release_step: ngs_pkg::UnityGain, hold_len: '0};
    cur_mode      = ngs_pkg::MODE_INIT;
    cur_gain      = '0;
    hold_cnt      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_sequence();
    test_ramp_extremes();
    test_random_settings();

    wait_drained();
    repeat (6) @(posedge clk_i);
    while (gate_results_q.size() != 0) begin
      void'(gate_results_q.pop_front());
      report_mismatch("missing result", '0, '0);
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
